[src/hpsc_pkg.sv]
// Package for the heading PI spin controller: register indexes, constants and stage types.
`default_nettype none
package hpsc_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] REG_INTEGRAL_ZONE = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_DRIVE_LIMIT   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_SETTLE_BAND   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_SETTLE_COUNT  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_TIMEOUT_MS    = 3'd4;

  localparam logic       OP_START  = 1'b0;
  localparam logic       OP_SAMPLE = 1'b1;

  localparam logic [7:0]  ZONE_RESET    = 8'd30;
  localparam logic [6:0]  LIMIT_RESET   = 7'd70;
  localparam logic [7:0]  BAND_RESET    = 8'd5;
  localparam logic [5:0]  COUNT_RESET   = 6'd15;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  localparam logic [5:0]  RUN_MAX = 6'd63;

  // Reciprocal of 125 in 2^-21 units; exact floor for quotients of values below 16000.
  localparam logic [14:0] RECIP_125 = 15'd16778;
  localparam int          RecipShift = 21;

  // Result kind that travels with an item through the drive stages.
  typedef struct packed {
    logic drv_en;
    logic fin;
    logic tout;
  } ctl_t;

endpackage
`default_nettype wire

[src/heading_pi_spin_controller_top.sv]
// Heading PI spin controller: state update, drive computation and output register.
// Result path: the stage 1 register, the stage 2 register, then the output register.
// Throughput: one item per clock while out_stall is low; the run state (integral,
// on-target run, run time) closes its loop in stage 1, so back-to-back samples never wait on it.
// The drive path after that is one more pipeline register feeding the output register.
// Reset (rst, synchronous): pipeline empty, controller idle, registers at their defaults.
`default_nettype none
module heading_pi_spin_controller_top #(
  parameter int INTEGRAL_WIDTH = 24
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_write,
  input  wire  [hpsc_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  wire  [hpsc_pkg::CfgDataWidth-1:0]     cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire                                   op,
  input  wire  signed [8:0]                     rel_heading,
  input  wire  [9:0]                            elapsed_ms,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [7:0]                     left_drive,
  output logic signed [7:0]                     right_drive,
  output logic                                  finished,
  output logic                                  timed_out
);
  import hpsc_pkg::*;

  // Width of the integral update sum: wide enough for the accumulator and the
  // 20-bit dt*error product, plus one bit of headroom.
  localparam int SW = ((INTEGRAL_WIDTH > 20) ? INTEGRAL_WIDTH : 20) + 1;
  // Width of the drive numerator 3000*err + acc.
  localparam int NW = ((INTEGRAL_WIDTH > 21) ? INTEGRAL_WIDTH : 21) + 1;

  localparam logic signed [SW-1:0] ACC_MAX =
    ({{(SW-1){1'b0}}, 1'b1} << (INTEGRAL_WIDTH - 1)) - {{(SW-1){1'b0}}, 1'b1};
  localparam logic signed [SW-1:0] ACC_MIN = -ACC_MAX - {{(SW-1){1'b0}}, 1'b1};
  localparam logic signed [NW-1:0] K_PROP = NW'(3000);

  // Configuration registers.
  logic [7:0]  integral_zone;
  logic [6:0]  drive_limit;
  logic [7:0]  settle_band;
  logic [5:0]  settle_count;
  logic [15:0] timeout_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_zone <= ZONE_RESET;
      drive_limit   <= LIMIT_RESET;
      settle_band   <= BAND_RESET;
      settle_count  <= COUNT_RESET;
      timeout_ms    <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INTEGRAL_ZONE: integral_zone <= cfg_data[7:0];
        REG_DRIVE_LIMIT:   drive_limit   <= cfg_data[6:0];
        REG_SETTLE_BAND:   settle_band   <= cfg_data[7:0];
        REG_SETTLE_COUNT:  settle_count  <= cfg_data[5:0];
        REG_TIMEOUT_MS:    timeout_ms    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Each stage takes a new item when it is empty or
  // when its content moves on, so bubbles fill even while the output waits.
  logic v1;
  logic v2;
  logic ready1;
  logic ready2;
  logic ready3;
  logic in_xfer;

  assign ready3   = !out_valid || !out_stall;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;
  assign in_xfer  = in_valid && ready1;

  // Run state.
  logic signed [INTEGRAL_WIDTH-1:0] integral_acc;
  logic [5:0]                       on_target_run;
  logic [15:0]                      run_time;
  logic                             running;

  logic signed [INTEGRAL_WIDTH-1:0] integral_acc_next;
  logic [5:0]                       on_target_run_next;
  logic [15:0]                      run_time_next;
  logic                             running_next;
  ctl_t                             ctl_next;

  logic [8:0]           err_mag;
  logic [16:0]          time_sum;
  logic [15:0]          time_sat;
  logic signed [19:0]   step_prod;
  logic signed [SW-1:0] acc_sum;
  logic [5:0]           run_inc;

  always_comb begin
    err_mag   = rel_heading[8] ? 9'(-rel_heading) : 9'(rel_heading);
    time_sum  = {1'b0, run_time} + {7'd0, elapsed_ms};
    time_sat  = time_sum[16] ? 16'hFFFF : time_sum[15:0];
    step_prod = $signed({10'd0, elapsed_ms}) * $signed({{11{rel_heading[8]}}, rel_heading});
    acc_sum   = SW'(integral_acc) + SW'(step_prod);
    run_inc   = (on_target_run == RUN_MAX) ? RUN_MAX : on_target_run + 6'd1;

    integral_acc_next  = integral_acc;
    on_target_run_next = on_target_run;
    run_time_next      = run_time;
    running_next       = running;
    ctl_next           = '{drv_en: 1'b0, fin: 1'b1, tout: 1'b0};

    if (op == OP_START) begin
      integral_acc_next  = '0;
      on_target_run_next = '0;
      run_time_next      = '0;
      running_next       = 1'b1;
      ctl_next           = '{drv_en: 1'b0, fin: 1'b0, tout: 1'b0};
    end else if (running) begin
      run_time_next = time_sat;
      if (time_sat >= timeout_ms) begin
        running_next = 1'b0;
        ctl_next     = '{drv_en: 1'b0, fin: 1'b1, tout: 1'b1};
      end else begin
        // Integrate only inside the zone; leaving it clears the integral.
        if (err_mag < {1'b0, integral_zone}) begin
          if (acc_sum > ACC_MAX) begin
            integral_acc_next = ACC_MAX[INTEGRAL_WIDTH-1:0];
          end else if (acc_sum < ACC_MIN) begin
            integral_acc_next = ACC_MIN[INTEGRAL_WIDTH-1:0];
          end else begin
            integral_acc_next = acc_sum[INTEGRAL_WIDTH-1:0];
          end
        end else begin
          integral_acc_next = '0;
        end
        on_target_run_next = (err_mag < {1'b0, settle_band}) ? run_inc : 6'd0;
        if (on_target_run_next > settle_count) begin
          running_next = 1'b0;
          ctl_next     = '{drv_en: 1'b0, fin: 1'b1, tout: 1'b0};
        end else begin
          ctl_next     = '{drv_en: 1'b1, fin: 1'b0, tout: 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc  <= '0;
      on_target_run <= '0;
      run_time      <= '0;
      running       <= 1'b0;
    end else if (in_xfer) begin
      integral_acc  <= integral_acc_next;
      on_target_run <= on_target_run_next;
      run_time      <= run_time_next;
      running       <= running_next;
    end
  end

  // Stage 1: error and updated integral of the item.
  ctl_t                             s1_ctl;
  logic signed [8:0]                s1_err;
  logic signed [INTEGRAL_WIDTH-1:0] s1_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_xfer) begin
      s1_ctl <= ctl_next;
      s1_err <= rel_heading;
      s1_acc <= integral_acc_next;
    end
  end

  // Stage 2: numerator, its magnitude and the clamp decision. A quotient above
  // the limit is exactly a magnitude at or above 2000*(limit+1).
  logic signed [NW-1:0] numer;
  logic [NW-1:0]        numer_abs;
  logic [17:0]          clamp_thr;
  logic                 clamp_hit;

  always_comb begin
    numer     = NW'(s1_acc) + NW'(s1_err) * K_PROP;
    numer_abs = numer[NW-1] ? NW'(-numer) : NW'(numer);
    clamp_thr = 18'd2000 * ({11'd0, drive_limit} + 18'd1);
    clamp_hit = numer_abs >= NW'(clamp_thr);
  end

  ctl_t        s2_ctl;
  logic        s2_neg;
  logic        s2_sat;
  logic [17:0] s2_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      s2_ctl <= s1_ctl;
      s2_neg <= numer[NW-1];
      s2_sat <= clamp_hit;
      s2_mag <= numer_abs[17:0];
    end
  end

  // Stage 3: divide the unclamped magnitude by 2000 as a shift by 4 and a
  // reciprocal multiply for 125, then apply sign and clamp; the drive is zero unless enabled.
  logic [28:0]       quot_prod;
  logic [7:0]        quot;
  logic [7:0]        drive_mag;
  logic signed [7:0] drive;

  always_comb begin
    quot_prod = {15'd0, s2_mag[17:4]} * {14'd0, RECIP_125};
    quot      = quot_prod[RecipShift+7:RecipShift];
    drive_mag = s2_sat ? {1'b0, drive_limit} : quot;
    if (!s2_ctl.drv_en) begin
      drive = '0;
    end else if (s2_neg) begin
      drive = -$signed(drive_mag);
    end else begin
      drive = $signed(drive_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      left_drive  <= drive;
      right_drive <= -drive;
      finished    <= s2_ctl.fin;
      timed_out   <= s2_ctl.tout;
    end
  end

endmodule
`default_nettype wire
